// File: rtl/mss_pkg.sv
// Package for the march sample synthesiser: state codes, register indexes and
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package mss_pkg;

    typedef enum logic [14:0] {
        S_FILL = 15'b000000000000001,
        S_IDLE = 15'b000000000000010,
        S_MP   = 15'b000000000000100,
        S_MB   = 15'b000000000001000,
        S_DF   = 15'b000000000010000,
        S_ME   = 15'b000000000100000,
        S_MR   = 15'b000000001000000,
        S_MI   = 15'b000000010000000,
        S_DI   = 15'b000000100000000,
        S_RD   = 15'b000001000000000,
        S_MX   = 15'b000010000000000,
        S_MG   = 15'b000100000000000,
        S_DG   = 15'b001000000000000,
        S_MD   = 15'b010000000000000,
        S_WT   = 15'b100000000000000
    } t_state;

    localparam logic [1:0] CFG_BEAT  = 2'd0;
    localparam logic [1:0] CFG_DECAY = 2'd1;
    localparam logic [1:0] CFG_GAIN  = 2'd2;

    localparam logic [31:0] BEAT_RST  = 32'd779132;
    localparam logic [23:0] DECAY_RST = 24'd16774933;
    localparam logic [14:0] GAIN_RST  = 15'd14000;
    localparam logic [23:0] LEVEL_TOP = 24'hFFFFFF;

    localparam logic [31:0] DUTY_042  = 32'd1803886264;
    localparam logic [31:0] HALF_TURN = 32'd2147483648;
    localparam logic [31:0] SNARE_WIN = 32'd107374182;
    localparam logic [31:0] BASS_WIN  = 32'd77309412;
    localparam logic [15:0] SHORT_LEN = 16'd23;
    localparam logic [16:0] ENV_ONE   = 17'd65536;
    localparam logic [16:0] ENV_HALF  = 17'd32768;

    localparam logic signed [17:0] LVL_BASE = 18'sd32768;
    localparam logic signed [17:0] LVL_3X   = 18'sd6554;
    localparam logic signed [17:0] LVL_15X  = 18'sd3277;

    localparam logic signed [25:0] K_BRASS   = 26'sd38;
    localparam logic signed [25:0] K_SNARE   = 26'sd6;
    localparam logic signed [25:0] K_BASS    = 26'sd15;
    localparam logic signed [25:0] K_STATIC  = 26'sd4;
    localparam logic signed [25:0] K_CRACKLE = 26'sd15;
    localparam logic signed [25:0] CLIP100   = 26'sd6225920;

    localparam logic [31:0] DIV_HUNDRED = 32'd100;
    localparam int          OUT_MAX     = 16383;
    localparam longint      Q30         = 64'sd1073741824;

endpackage

// File: rtl/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/march_sample_synth.sv
// March sample synthesiser top level: sequencer, shared bit-serial multiplier
// and restoring divider, mixer. Depends on mss_pkg and mss_ram.
// Multiplier and divider each work one bit per cycle; the divider quotient is DW = 33 + clog2(BASS_TABLE_DEPTH)
// bits wide. A stalled result holds the wait state.
// One transaction at a time; the next is taken while a finished sample waits.
// Reset: synchronous; the bass table is then filled, all BASS_TABLE_DEPTH entries, before input.
`timescale 1ns / 1ps

module march_sample_synth #(
    parameter int BASS_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_phase_step,
    input  logic [15:0]        i_note_offset,
    input  logic [15:0]        i_note_length,
    input  logic               i_tune_start,
    input  logic signed [15:0] i_snare_noise,
    input  logic signed [15:0] i_static_noise,
    input  logic               i_crackle_fire,
    input  logic signed [15:0] i_crackle_noise,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_sample,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    import mss_pkg::*;

    localparam int AW  = $clog2(BASS_TABLE_DEPTH);
    localparam int DW  = 33 + AW;
    localparam int CW  = $clog2(DW);
    localparam int LIM = ((1 << (SAMPLE_WIDTH - 1)) - 1) > OUT_MAX ? OUT_MAX
                         : ((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam longint W_STEP = longint'((64'd9047520 << 30)
                                         / (64'd1000000 * BASS_TABLE_DEPTH));
    localparam longint A_STEP = longint'((64'd126 * 64'd1073741824)
                                         / (64'd100 * BASS_TABLE_DEPTH));

    function automatic logic [BASS_TABLE_DEPTH*16-1:0] f_bass_rom();
        logic [BASS_TABLE_DEPTH*16-1:0] t;
        longint w2, w3, w4, c, a2, a3, r, sa, sb, e, v, nx;
        t  = '0;
        w2 = W_STEP * W_STEP / Q30;
        w3 = w2 * W_STEP / Q30;
        w4 = w2 * w2 / Q30;
        c  = Q30 - w2 / 2 + w4 / 24;
        a2 = A_STEP * A_STEP / Q30;
        a3 = a2 * A_STEP / Q30;
        r  = Q30 - A_STEP + a2 / 2 - a3 / 6;
        sa = 0;
        sb = W_STEP - w3 / 6;
        e  = Q30;
        for (int n = 0; n < BASS_TABLE_DEPTH; n++) begin
            v = (sa * e) / Q30;
            v = v * 35 / (100 * 16384);
            t[n*16 +: 16] = v[15:0];
            nx = (2 * c * sb) / Q30 - sa;
            sa = sb;
            sb = nx;
            e  = e * r / Q30;
        end
        return t;
    endfunction

    localparam logic [BASS_TABLE_DEPTH*16-1:0] ROM_INIT = f_bass_rom();

    t_state r_state, n_state;

    logic [31:0]        r_beat;
    logic [23:0]        r_decay;
    logic [14:0]        r_gain;
    logic [31:0]        r_smp;
    logic [23:0]        r_level;
    logic [AW-1:0]      r_fill;

    logic [31:0]        r_step;
    logic [15:0]        r_off;
    logic [15:0]        r_len;
    logic signed [15:0] r_snare_n;
    logic signed [15:0] r_static_n;
    logic               r_fire;
    logic signed [15:0] r_crackle_n;

    logic [CW-1:0]      r_cnt;
    logic [31:0]        r_mul_a;
    logic [63:0]        r_mul_p;
    logic [DW-1:0]      r_div_q;
    logic [31:0]        r_div_r;
    logic [31:0]        r_div_d;

    logic [32:0]        r_phase;
    logic [1:0]         r_beats;
    logic [31:0]        r_frac;
    logic               r_snare_on;
    logic               r_bass_on;
    logic signed [17:0] r_brass;
    logic [AW-1:0]      r_raddr;
    logic               r_mix_neg;
    logic [14:0]        r_res;

    logic [32:0]        mul_sum;
    logic [63:0]        mul_nxt;
    logic [32:0]        div_t;
    logic [32:0]        div_sub;
    logic               div_ge;
    logic [DW-1:0]      div_q_nxt;
    logic [31:0]        div_r_nxt;
    logic               last;
    logic               accept;
    logic [31:0]        smp_new;
    logic [15:0]        diff;
    logic [16:0]        env_base;
    logic               short_note;
    logic               fade_on;
    logic [34:0]        p3;
    logic signed [17:0] brass_lvl;
    logic [17:0]        brass_abs;
    logic [15:0]        ram_q;
    logic signed [25:0] bass_v;
    logic signed [25:0] snare_v;
    logic signed [25:0] crackle_v;
    logic signed [25:0] mix_raw;
    logic signed [25:0] mix_clip;
    logic [25:0]        mix_abs;
    logic [DW-1:0]      mag;
    logic [14:0]        mag_lim;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign last        = (r_cnt == '0);
    assign smp_new     = i_tune_start ? 32'd0 : r_smp;

    assign mul_sum   = {1'b0, r_mul_p[63:32]} + (r_mul_p[0] ? {1'b0, r_mul_a} : 33'd0);
    assign mul_nxt   = {mul_sum, r_mul_p[31:1]};
    assign div_t     = {r_div_r, r_div_q[DW-1]};
    assign div_ge    = (div_t >= {1'b0, r_div_d});
    assign div_sub   = div_t - {1'b0, r_div_d};
    assign div_r_nxt = div_ge ? div_sub[31:0] : div_t[31:0];
    assign div_q_nxt = {r_div_q[DW-2:0], div_ge};

    assign diff       = r_len - r_off;
    assign env_base   = {2'd0, r_level[23:9]} + ENV_HALF;
    assign short_note = (r_len < SHORT_LEN);
    assign fade_on    = (({4'd0, r_off} << 3) + ({4'd0, r_off} << 1))
                        > (({4'd0, r_len} << 3) + {4'd0, r_len});

    assign p3        = {1'b0, r_phase, 1'b0} + {2'b0, r_phase};
    assign brass_lvl = ((r_phase[31:0] < DUTY_042) ? LVL_BASE : -LVL_BASE)
                     + ((p3[31:0] < HALF_TURN) ? LVL_3X : -LVL_3X)
                     + ((p3[32:1] < HALF_TURN) ? LVL_15X : -LVL_15X);
    assign brass_abs = brass_lvl[17] ? 18'(-brass_lvl) : 18'(brass_lvl);

    assign bass_v    = r_bass_on ? 26'(signed'(ram_q)) : 26'sd0;
    assign snare_v   = r_snare_on ? 26'(r_snare_n) : 26'sd0;
    assign crackle_v = r_fire ? 26'(r_crackle_n) * K_CRACKLE : 26'sd0;
    assign mix_raw   = 26'(r_brass) * K_BRASS + snare_v * K_SNARE + bass_v * K_BASS
                     + 26'(r_static_n) * K_STATIC + crackle_v;
    assign mix_clip  = (mix_raw > CLIP100) ? CLIP100
                     : ((mix_raw < -CLIP100) ? -CLIP100 : mix_raw);
    assign mix_abs   = mix_clip[25] ? 26'(-mix_clip) : 26'(mix_clip);

    assign mag     = div_q_nxt;
    assign mag_lim = (mag > DW'(LIM)) ? 15'(LIM) : mag[14:0];

    mss_ram #(
        .WIDTH (16),
        .DEPTH (BASS_TABLE_DEPTH)
    ) u_bass_rom (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FILL),
        .i_waddr (r_fill),
        .i_wdata (ROM_INIT[{r_fill, 4'b0} +: 16]),
        .i_raddr (r_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL: if (r_fill == AW'(BASS_TABLE_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_MP;
            S_MP:   if (last) n_state = S_MB;
            S_MB:   if (last) n_state = S_DF;
            S_DF:   if (last) n_state = S_ME;
            S_ME:   if (last) n_state = S_MR;
            S_MR:   if (last) n_state = S_MI;
            S_MI:   if (last) n_state = S_DI;
            S_DI:   if (last) n_state = S_RD;
            S_RD:   n_state = S_MX;
            S_MX:   n_state = S_MG;
            S_MG:   if (last) n_state = S_DG;
            S_DG:   if (last) n_state = S_MD;
            S_MD:   if (last) n_state = S_WT;
            S_WT:   if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_beat  <= BEAT_RST;
            r_decay <= DECAY_RST;
            r_gain  <= GAIN_RST;
            r_smp   <= '0;
            r_level <= LEVEL_TOP;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FILL) begin
                r_fill <= r_fill + AW'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BEAT:  r_beat  <= i_cfg_data;
                    CFG_DECAY: r_decay <= i_cfg_data[23:0];
                    CFG_GAIN:  r_gain  <= i_cfg_data[14:0];
                    default:   ;
                endcase
            end
            if (accept) begin
                r_smp <= smp_new;
                if (i_note_offset == 16'd0) begin
                    r_level <= LEVEL_TOP;
                end
            end
            if (r_state == S_MD && last) begin
                r_level <= mul_nxt[47:24];
                r_smp   <= r_smp + 32'd1;
            end
            if (r_state == S_WT && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= r_cnt - CW'(1);
        r_mul_p <= mul_nxt;
        r_div_q <= div_q_nxt;
        r_div_r <= div_r_nxt;
        case (r_state)
            S_IDLE: begin
                r_step      <= i_phase_step;
                r_off       <= i_note_offset;
                r_len       <= i_note_length;
                r_snare_n   <= i_snare_noise;
                r_static_n  <= i_static_noise;
                r_fire      <= i_crackle_fire;
                r_crackle_n <= i_crackle_noise;
                r_mul_a     <= i_phase_step;
                r_mul_p     <= {32'd0, smp_new};
                r_cnt       <= CW'(31);
            end
            S_MP: if (last) begin
                r_phase <= mul_nxt[32:0];
                r_mul_a <= r_beat;
                r_mul_p <= {32'd0, r_smp};
                r_cnt   <= CW'(31);
            end
            S_MB: if (last) begin
                r_beats    <= mul_nxt[33:32];
                r_frac     <= mul_nxt[31:0];
                r_snare_on <= mul_nxt[32] && (mul_nxt[31:0] != 32'd0)
                              && (mul_nxt[31:0] <= SNARE_WIN);
                r_div_q    <= (DW'(diff) << 19) + (DW'(diff) << 17);
                r_div_r    <= '0;
                r_div_d    <= {16'd0, r_len};
                r_cnt      <= CW'(DW - 1);
            end
            S_DF: if (last) begin
                r_mul_a <= {15'd0, env_base};
                r_mul_p <= {32'd0, (r_off < r_len) ? div_q_nxt[31:0] : 32'd0};
                r_cnt   <= CW'(31);
            end
            S_ME: if (last) begin
                r_mul_a <= {14'd0, brass_abs};
                r_mul_p <= {32'd0, 15'd0,
                            short_note ? ENV_ONE : (fade_on ? mul_nxt[32:16] : env_base)};
                r_cnt   <= CW'(31);
            end
            S_MR: if (last) begin
                if (r_step == 32'd0) begin
                    r_brass <= 18'sd0;
                end else if (brass_lvl[17]) begin
                    r_brass <= -signed'({1'b0, mul_nxt[32:16]});
                end else begin
                    r_brass <= signed'({1'b0, mul_nxt[32:16]});
                end
                r_mul_a <= r_frac;
                r_mul_p <= {32'd0, 32'(BASS_TABLE_DEPTH)};
                r_cnt   <= CW'(31);
            end
            S_MI: if (last) begin
                r_div_q <= mul_nxt[DW-1:0];
                r_div_r <= '0;
                r_div_d <= BASS_WIN;
                r_cnt   <= CW'(DW - 1);
            end
            S_DI: if (last) begin
                r_bass_on <= !r_beats[0] && (r_frac < BASS_WIN)
                             && (div_q_nxt < DW'(BASS_TABLE_DEPTH));
                r_raddr   <= div_q_nxt[AW-1:0];
            end
            S_MX: begin
                r_mix_neg <= mix_clip[25];
                r_mul_a   <= {6'd0, mix_abs};
                r_mul_p   <= {32'd0, 17'd0, r_gain};
                r_cnt     <= CW'(31);
            end
            S_MG: if (last) begin
                r_div_q <= DW'(mul_nxt[63:16]);
                r_div_r <= '0;
                r_div_d <= DIV_HUNDRED;
                r_cnt   <= CW'(DW - 1);
            end
            S_DG: if (last) begin
                r_res   <= r_mix_neg ? 15'(-mag_lim) : mag_lim;
                r_mul_a <= {8'd0, r_level};
                r_mul_p <= {32'd0, 8'd0, r_decay};
                r_cnt   <= CW'(31);
            end
            S_WT: if (!o_valid || i_ready) begin
                o_sample <= r_res;
            end
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_MP))
        else $error("accepted transaction did not start the phase multiply");

    a_valid_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_WT))
        else $error("result raised outside the output wait state");

    a_counter_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MD && last) |=> (r_smp == $past(r_smp) + 32'd1))
        else $error("sample counter did not advance at end of transaction");

endmodule

// File: tb/tb.sv
// Self-checking testbench for march_sample_synth: directed table then random
// transactions, each sample checked against an in-bench predictor. Needs mss_pkg.
`timescale 1ns / 1ps

module tb;
    import mss_pkg::*;

    localparam int DEPTH = 1024;
    localparam int SW    = 16;

    typedef struct {
        logic [31:0]        step;
        logic [15:0]        offset;
        logic [15:0]        len;
        logic               start;
        logic signed [15:0] snare;
        logic signed [15:0] stat;
        logic               fire;
        logic signed [15:0] crackle;
    } t_note;

    typedef struct {
        t_note              n;
        bit                 known;
        logic signed [14:0] want;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [31:0] i_phase_step;
    logic [15:0] i_note_offset, i_note_length;
    logic i_tune_start, i_crackle_fire;
    logic signed [15:0] i_snare_noise, i_static_noise, i_crackle_noise;
    logic signed [14:0] o_sample;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    march_sample_synth #(.BASS_TABLE_DEPTH(DEPTH), .SAMPLE_WIDTH(SW)) dut (.*);

    logic signed [15:0] thump_rom [DEPTH];
    logic [31:0] counter;
    logic [23:0] level;
    logic [31:0] beat_step;
    logic [23:0] decay;
    logic [14:0] gain;
    logic signed [14:0] pending_samples [$];
    int errors;
    int send_idle, recv_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("march_sample_synth: mismatch");
        $finish;
    end

    function automatic longint tdiv(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    task automatic fill_thump();
        longint w, w2, w3, w4, c, a, a2, a3, r, sa, sb, e, v, nx;
        w  = (64'd9047520 << 30) / (64'd1000000 * DEPTH);
        w2 = tdiv(w * w, Q30);
        w3 = tdiv(w2 * w, Q30);
        w4 = tdiv(w2 * w2, Q30);
        c  = Q30 - tdiv(w2, 2) + tdiv(w4, 24);
        a  = (126 * Q30) / (100 * DEPTH);
        a2 = tdiv(a * a, Q30);
        a3 = tdiv(a2 * a, Q30);
        r  = Q30 - a + tdiv(a2, 2) - tdiv(a3, 6);
        sa = 0;
        sb = w - tdiv(w3, 6);
        e  = Q30;
        for (int k = 0; k < DEPTH; k++) begin
            v = tdiv(sa * e, Q30);
            v = tdiv(v * 35, 100 * 16384);
            thump_rom[k] = v[15:0];
            nx = tdiv(2 * c * sb, Q30) - sa;
            sa = sb;
            sb = nx;
            e  = tdiv(e * r, Q30);
        end
    endtask

    function automatic logic signed [14:0] synth_sample(t_note n);
        longint env, fade, brass, bass, snare, mix, res, lim;
        logic [32:0] ph;
        logic [34:0] ph3;
        logic [63:0] prod;
        logic [31:0] frac;
        longint idx;
        brass = 0; bass = 0; snare = 0;
        if (n.start) counter = 0;
        if (n.offset == 0) level = LEVEL_TOP;
        env = 65536;
        if (longint'(n.len) * 1000 > 22050) begin
            env = (level >> 9) + 32768;
            if (10 * longint'(n.offset) > 9 * longint'(n.len)) begin
                fade = (n.offset < n.len) ?
                       (longint'(n.len - n.offset) * 655360) / n.len : 0;
                env = (env * fade) >> 16;
            end
        end
        if (n.step != 0) begin
            prod = 64'(counter) * 64'(n.step);
            ph = prod[32:0];
            ph3 = 35'(ph) * 3;
            brass = (ph[31:0] < DUTY_042) ? 32768 : -32768;
            brass += (ph3[31:0] < HALF_TURN) ? 6554 : -6554;
            brass += (ph3[32:1] < HALF_TURN) ? 3277 : -3277;
            brass = tdiv(brass * env, 65536);
        end
        prod = 64'(counter) * 64'(beat_step);
        frac = prod[31:0];
        if (prod[32] && frac >= 1 && frac <= SNARE_WIN) snare = n.snare;
        if (!prod[32] && frac < BASS_WIN) begin
            idx = (longint'(frac) * DEPTH) / BASS_WIN;
            if (idx < DEPTH) bass = thump_rom[idx];
        end
        mix = brass * 38 + snare * 6 + bass * 15 + longint'(n.stat) * 4;
        if (n.fire) mix += longint'(n.crackle) * 15;
        if (mix > CLIP100) mix = CLIP100;
        if (mix < -CLIP100) mix = -CLIP100;
        res = tdiv(mix * gain, 100 * 65536);
        lim = (64'sd1 << (SW - 1)) - 1;
        if (lim > OUT_MAX) lim = OUT_MAX;
        if (res > lim) res = lim;
        if (res < -lim) res = -lim;
        level = 24'((64'(level) * 64'(decay)) >> 24);
        counter = counter + 1;
        return res[14:0];
    endfunction

    function automatic t_note random_note(int k);
        t_note n;
        int len;
        n.step = ($urandom_range(0, 7) == 0) ? 32'd0 :
                 ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(100000, 200000000);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) :
              ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(23, 400);
        n.len = 16'(len);
        n.offset = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'(k % (len + 1));
        n.start = ($urandom_range(0, 99) == 0);
        n.snare = 16'($urandom());
        n.stat = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000) - 1000);
        n.fire = ($urandom_range(0, 19) == 0);
        n.crackle = 16'($urandom());
        return n;
    endfunction

    task automatic send_note(t_note n, bit known, logic signed [14:0] want);
        logic signed [14:0] p;
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        p = synth_sample(n);
        if (known && p !== want) begin
            errors++;
            if (errors <= 10)
                $display("table row: predicted %0d, typed %0d", p, want);
        end
        pending_samples.push_back(p);
        i_valid <= 1'b1;
        i_phase_step <= n.step;
        i_note_offset <= n.offset;
        i_note_length <= n.len;
        i_tune_start <= n.start;
        i_snare_noise <= n.snare;
        i_static_noise <= n.stat;
        i_crackle_fire <= n.fire;
        i_crackle_noise <= n.crackle;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BEAT:  beat_step = val;
            CFG_DECAY: decay = val[23:0];
            CFG_GAIN:  gain = val[14:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_samples.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected sample %0d", o_sample);
                end else begin
                    if (o_sample !== pending_samples[0]) begin
                        errors++;
                        if (errors <= 10)
                            $display("sample: expected %0d, got %0d",
                                     pending_samples[0], o_sample);
                    end
                    void'(pending_samples.pop_front());
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    t_row rows [$];

    task automatic add_row(logic [31:0] st, logic [15:0] off, logic [15:0] len,
                           logic s, logic [15:0] sn, logic [15:0] stn, logic f,
                           logic [15:0] cn, bit known, logic signed [14:0] want);
        t_row r;
        r.n = '{st, off, len, s, sn, stn, f, cn};
        r.known = known;
        r.want = want;
        rows.push_back(r);
    endtask

    initial begin
        logic [31:0] beats [4];
        logic [23:0] decays [3];
        logic [14:0] gains [4];
        int k;
        beats = '{32'd779132, 32'd0, 32'hFFFF_FFFF, 32'd40000000};
        decays = '{24'd16774933, 24'd0, 24'hFFFFFF};
        gains = '{15'd14000, 15'd0, 15'h7FFF, 15'd9000};
        errors = 0;
        send_idle = 14;
        recv_idle = 54;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BEAT;
        i_cfg_data = '0;
        i_phase_step = '0;
        i_note_offset = '0;
        i_note_length = '0;
        i_tune_start = 1'b0;
        i_snare_noise = '0;
        i_static_noise = '0;
        i_crackle_fire = 1'b0;
        i_crackle_noise = '0;
        fill_thump();
        counter = 0;
        level = LEVEL_TOP;
        beat_step = BEAT_RST;
        decay = DECAY_RST;
        gain = GAIN_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // rest, counter zero after reset: only static reaches the mix
        add_row(0, 0, 100, 1, 16'h7FFF, 16'h0000, 0, 0, 1, 15'sd0);
        add_row(0, 1, 100, 0, 0, 16'h7FFF, 0, 0, 0, 0);
        add_row(0, 2, 100, 1, 0, 16'h7FFF, 1, 16'h7FFF, 0, 0);
        add_row(0, 3, 100, 0, 0, 16'h8000, 1, 16'h8000, 0, 0);
        add_row(32'hFFFF_FFFF, 0, 16'hFFFF, 0, 16'h8000, 16'h7FFF, 1, 16'h7FFF, 0, 0);
        add_row(32'd1, 16'hFFFF, 16'hFFFF, 0, 16'h7FFF, 16'h8000, 0, 0, 0, 0);
        add_row(32'h8000_0000, 10, 22, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h1000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h1000_0000, 95, 100, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h1000_0000, 100, 100, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h1000_0000, 200, 100, 0, 0, 0, 0, 0, 0, 0);
        add_row(32'h2000_0000, 90, 100, 0, 16'h5555, 16'hAAAA, 1, 16'h5555, 0, 0);
        add_row(32'd12345678, 5, 23, 0, 16'hAAAA, 16'h5555, 1, 16'hAAAA, 0, 0);
        foreach (rows[i]) send_note(rows[i].n, rows[i].known, rows[i].want);

        for (int ph = 0; ph < 3; ph++) begin
            for (int b = 0; b < 4; b++) begin
                write_reg(CFG_BEAT, beats[(b + ph) % 4]);
                write_reg(CFG_DECAY, {8'h0, decays[(b + ph) % 3]});
                write_reg(CFG_GAIN, {17'h0, gains[b]});
                for (k = 0; k < 140; k++) begin
                    if (k == 70) while ($urandom_range(0, 1)) @(posedge i_clk);
                    send_note(random_note(k), 0, 0);
                end
            end
            if (ph == 0) begin
                send_idle = 54;
                recv_idle = 14;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
        end

        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("march_sample_synth: match");
        end else begin
            $display("march_sample_synth: mismatch");
        end
        $finish;
    end
endmodule
